/* rtl/ura_pkg.sv */
package ura_pkg;

  // Default echo counter width
  localparam int ECHO_WIDTH_DEF = 16;

  // Fixed field and register widths
  localparam int TRIG_W = 8;
  localparam int GAP_W  = 17;
  localparam int TEMP_W = 12;
  localparam int DIST_W = 18;
  localparam int SUM_W  = 20;
  localparam int CFG_W  = 17;

  // Speed-of-sound factor: 5304*1024 + 622*temp, always positive, 23 bits
  localparam int K_W = 23;
  localparam int KX_W = 24;
  localparam logic signed [KX_W-1:0] BASE_FACTOR = 24'sd5431296;
  localparam logic signed [KX_W-1:0] TEMP_FACTOR = 24'sd622;

  // 3276800 = 2^17 * 25: shift, then divide by 25
  localparam int PROD_SHIFT = 17;
  localparam int DIVR_W = 5;
  localparam logic [DIVR_W-1:0] DIV_SAMPLE = 5'd25;
  localparam logic [DIVR_W-1:0] DIV_AVG    = 5'd5;

  localparam logic [2:0] SAMPLES = 3'd5;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register reset values
  localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd20;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 17'd50000;

  // Register indexes
  localparam logic CFG_TRIG = 1'b0;
  localparam logic CFG_GAP  = 1'b1;

  // Ranging phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_ECHO,
    PH_GAP
  } phase_t;

  // Sequencer state for one word
  typedef enum logic [2:0] {
    C_IDLE,
    C_STEP,
    C_MUL,
    C_DIV,
    C_OUT
  } ctl_t;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DIVR_W-1:0] divisor;
  } div_ctl_t;

endpackage

/* rtl/ultrasonic_range_averager_top.sv */
// Ultrasonic ranger with temperature compensation, averaging five echoes.
// Each input word is one microsecond tick and yields exactly one output word
// showing trigger, busy, done and, on the done tick, the average distance in
// 0.01 cm. A plain tick passes from acceptance through the step and output
// states to a loaded output register. The tick on which echo falls and the
// tick that delivers the average also go through the shared constant divider,
// a registered reciprocal multiply used for the per-sample divide by 25 and
// for the final divide by 5. A full output register adds the cycles until it
// is taken. The input is not ready while a word is in progress. The output
// register holds a word until taken while the next tick is accepted.
// Configuration writes are taken at any time but are meant for idle periods.
module ultrasonic_range_averager_top #(
  parameter int ECHO_WIDTH = ura_pkg::ECHO_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // start_req, echo, temperature[11:0], zero pad
  // Output words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // trigger, busy_res, done_res, distance[17:0], zero pad
  // Configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [ura_pkg::CFG_W-1:0] cfg_data
);

  localparam int DIV_W  = (ECHO_WIDTH + 6 > ura_pkg::SUM_W) ? ECHO_WIDTH + 6 : ura_pkg::SUM_W;
  localparam int ADD_W  = DIV_W + 1;
  localparam int PROD_W = ECHO_WIDTH + ura_pkg::K_W;

  // Configuration registers
  logic [ura_pkg::TRIG_W-1:0] trig_ticks_r;
  logic [ura_pkg::GAP_W-1:0]  gap_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= ura_pkg::TRIG_RESET;
      gap_ticks_r  <= ura_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ura_pkg::CFG_TRIG: trig_ticks_r <= cfg_data[ura_pkg::TRIG_W-1:0];
        ura_pkg::CFG_GAP:  gap_ticks_r  <= cfg_data[ura_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and ranging state
  ura_pkg::ctl_t   ctl_r, ctl_nxt;
  ura_pkg::phase_t phase_r, phase_nxt;
  logic [ura_pkg::GAP_W-1:0]  tick_r, tick_nxt;
  logic [ECHO_WIDTH-1:0]      echo_time_r, echo_time_nxt;
  logic [2:0]                 sample_r, sample_nxt;
  logic [ura_pkg::SUM_W-1:0]  sum_r, sum_nxt;

  // Latched input word and per-word working values
  logic                              start_r, start_nxt;
  logic                              echo_r, echo_nxt;
  logic signed [ura_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic [ura_pkg::K_W-1:0]           k_r, k_nxt;
  logic                              avg_mode_r, avg_mode_nxt;
  logic                              done_r, done_nxt;
  logic [ura_pkg::DIST_W-1:0]        avg_r, avg_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // Divider link
  ura_pkg::div_ctl_t div_ctl;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_quo;
  logic              div_done;

  ura_cdiv #(
    .W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Arithmetic helpers
  logic signed [ura_pkg::KX_W-1:0] temp_x;
  logic signed [ura_pkg::KX_W-1:0] k_s;
  logic [PROD_W-1:0]               prod;
  logic [ADD_W-1:0]                sum_add;

  always_comb begin
    temp_x  = ura_pkg::KX_W'(temp_r);
    k_s     = ura_pkg::BASE_FACTOR + temp_x * ura_pkg::TEMP_FACTOR;
    prod    = PROD_W'(echo_time_r) * PROD_W'(k_r);
    sum_add = ADD_W'(sum_r) + ADD_W'(div_quo);
  end

  assign in_tready  = (ctl_r == ura_pkg::C_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state and outputs
  always_comb begin
    ctl_nxt       = ctl_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    echo_time_nxt = echo_time_r;
    sample_nxt    = sample_r;
    sum_nxt       = sum_r;
    start_nxt     = start_r;
    echo_nxt      = echo_r;
    temp_nxt      = temp_r;
    k_nxt         = k_r;
    avg_mode_nxt  = avg_mode_r;
    done_nxt      = done_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_ctl.start   = 1'b0;
    div_ctl.divisor = ura_pkg::DIV_SAMPLE;
    div_dividend    = DIV_W'(prod >> ura_pkg::PROD_SHIFT);

    // Drain the output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (ctl_r)
      ura_pkg::C_IDLE: begin
        if (in_tvalid) begin
          start_nxt = in_tdata[0];
          echo_nxt  = in_tdata[1];
          temp_nxt  = $signed(in_tdata[13:2]);
          ctl_nxt   = ura_pkg::C_STEP;
        end
      end

      ura_pkg::C_STEP: begin
        done_nxt = 1'b0;
        avg_nxt  = '0;
        k_nxt    = k_s[ura_pkg::K_W-1:0];
        ctl_nxt  = ura_pkg::C_OUT;
        case (phase_r)
          ura_pkg::PH_TRIG: begin
            if (tick_r >= ura_pkg::GAP_W'(trig_ticks_r)) begin
              phase_nxt = ura_pkg::PH_RISE;
              tick_nxt  = '0;
            end else begin
              tick_nxt = tick_r + 1'b1;
            end
          end
          ura_pkg::PH_RISE: begin
            if (echo_r) begin
              phase_nxt     = ura_pkg::PH_ECHO;
              echo_time_nxt = ECHO_WIDTH'(1);
            end
          end
          ura_pkg::PH_ECHO: begin
            if (echo_r) begin
              if (echo_time_r != '1) begin
                echo_time_nxt = echo_time_r + 1'b1;
              end
            end else begin
              // Convert this sample; sum is added after the divide
              sample_nxt   = sample_r + 1'b1;
              phase_nxt    = ura_pkg::PH_GAP;
              tick_nxt     = '0;
              avg_mode_nxt = 1'b0;
              ctl_nxt      = ura_pkg::C_MUL;
            end
          end
          ura_pkg::PH_GAP: begin
            if (tick_r >= gap_ticks_r) begin
              if (sample_r >= ura_pkg::SAMPLES) begin
                // Average the five samples
                done_nxt        = 1'b1;
                phase_nxt       = ura_pkg::PH_IDLE;
                tick_nxt        = '0;
                avg_mode_nxt    = 1'b1;
                div_ctl.start   = 1'b1;
                div_ctl.divisor = ura_pkg::DIV_AVG;
                div_dividend    = DIV_W'(sum_r);
                ctl_nxt         = ura_pkg::C_DIV;
              end else begin
                phase_nxt = ura_pkg::PH_TRIG;
                tick_nxt  = ura_pkg::GAP_W'(1);
              end
            end else begin
              tick_nxt = tick_r + 1'b1;
            end
          end
          default: begin
            phase_nxt = ura_pkg::PH_IDLE;
            if (start_r) begin
              phase_nxt     = ura_pkg::PH_TRIG;
              tick_nxt      = ura_pkg::GAP_W'(1);
              echo_time_nxt = '0;
              sample_nxt    = '0;
              sum_nxt       = '0;
            end
          end
        endcase
      end

      ura_pkg::C_MUL: begin
        // Scaled product into the divider, divide by 25
        div_ctl.start   = 1'b1;
        div_ctl.divisor = ura_pkg::DIV_SAMPLE;
        ctl_nxt         = ura_pkg::C_DIV;
      end

      ura_pkg::C_DIV: begin
        if (div_done) begin
          if (avg_mode_r) begin
            avg_nxt = (div_quo > DIV_W'(ura_pkg::DIST_MAX)) ? ura_pkg::DIST_MAX
                                                          : div_quo[ura_pkg::DIST_W-1:0];
          end else begin
            sum_nxt = (sum_add > ADD_W'(ura_pkg::SUM_MAX)) ? ura_pkg::SUM_MAX
                                                          : sum_add[ura_pkg::SUM_W-1:0];
          end
          ctl_nxt = ura_pkg::C_OUT;
        end
      end

      ura_pkg::C_OUT: begin
        // Load the result word once the register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, avg_r, done_r,
                           (phase_r != ura_pkg::PH_IDLE),
                           (phase_r == ura_pkg::PH_TRIG)};
          ctl_nxt       = ura_pkg::C_IDLE;
        end
      end

      default: begin
        ctl_nxt = ura_pkg::C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= ura_pkg::C_IDLE;
      phase_r     <= ura_pkg::PH_IDLE;
      tick_r      <= '0;
      echo_time_r <= '0;
      sample_r    <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      echo_time_r <= echo_time_nxt;
      sample_r    <= sample_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r    <= start_nxt;
    echo_r     <= echo_nxt;
    temp_r     <= temp_nxt;
    k_r        <= k_nxt;
    avg_mode_r <= avg_mode_nxt;
    done_r     <= done_nxt;
    avg_r      <= avg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/ura_cdiv.sv */
// Constant divider by reciprocal multiplication for the two divisors in use:
// DIV_SAMPLE (25, one sample) and DIV_AVG (5, the average). Any other divisor
// code is taken as DIV_SAMPLE. With M = ceil(2^s / d) and s = W + clog2(d),
// floor(x * M / 2^s) equals floor(x / d) for every W-bit x.
// The dividend is taken on start, the product is registered on the next cycle
// and done pulses together with it; the quotient holds until the next start.
module ura_cdiv #(
  parameter int W = 22
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ura_pkg::div_ctl_t    ctl,
  input  logic [W-1:0]         dividend,
  output logic [W-1:0]         quotient,
  output logic                 done
);

  localparam int     MW        = W + 1;
  localparam int     PW        = W + MW;
  localparam longint ONE       = 1;
  localparam longint D_SAMPLE  = longint'(ura_pkg::DIV_SAMPLE);
  localparam longint D_AVG     = longint'(ura_pkg::DIV_AVG);
  localparam int     SH_SAMPLE = W + $clog2(int'(ura_pkg::DIV_SAMPLE));
  localparam int     SH_AVG    = W + $clog2(int'(ura_pkg::DIV_AVG));
  localparam logic [MW-1:0] REC_SAMPLE =
    MW'(((ONE << SH_SAMPLE) + D_SAMPLE - 1) / D_SAMPLE);
  localparam logic [MW-1:0] REC_AVG =
    MW'(((ONE << SH_AVG) + D_AVG - 1) / D_AVG);

  logic [W-1:0]  x_r, x_nxt;
  logic          avg_r, avg_nxt;
  logic          busy_r, busy_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          done_r, done_nxt;
  logic [MW-1:0] rec;

  // Take the dividend, then multiply by the reciprocal
  always_comb begin
    x_nxt    = x_r;
    avg_nxt  = avg_r;
    busy_nxt = 1'b0;
    prod_nxt = prod_r;
    done_nxt = 1'b0;
    rec      = avg_r ? REC_AVG : REC_SAMPLE;
    if (ctl.start) begin
      x_nxt    = dividend;
      avg_nxt  = (ctl.divisor == ura_pkg::DIV_AVG);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = PW'(x_r) * PW'(rec);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    avg_r  <= avg_nxt;
    prod_r <= prod_nxt;
  end

  // Drop the fraction bits
  assign quotient = avg_r ? W'(prod_r >> SH_AVG) : W'(prod_r >> SH_SAMPLE);
  assign done     = done_r;

endmodule

/* test/tb_ultrasonic_range_averager_top.sv */
module tb_ultrasonic_range_averager_top;
  import ura_pkg::*;

  // Conversion constants: distance = t * (base + slope * temp) / scale
  localparam longint SOUND_BASE = 5304 * 1024;
  localparam longint SOUND_SLOPE = 622;
  localparam longint RANGE_SCALE = 3276800;
  localparam int AVG_COUNT = 5;
  localparam longint SUM_CEIL = (64'd1 << SUM_W) - 1;
  localparam longint DIST_CEIL = (64'd1 << DIST_W) - 1;
  localparam int ECHO_W = ECHO_WIDTH_DEF;

  // Slowest run: about 1200 words plus stalls, many times over
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              echo;
    logic              start_req;
  } tick_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              done_res;
    logic              busy_res;
    logic              trigger;
  } range_word_t;

  // Track the ranger state and hold the range words still to come
  class range_scoreboard;
    logic [TRIG_W-1:0] trig_len;
    logic [GAP_W-1:0]  gap_len;
    phase_t            phase;
    logic [GAP_W-1:0]  tick_cnt;
    logic [ECHO_W-1:0] echo_cnt;
    logic [2:0]        sample_idx;
    logic [SUM_W-1:0]  dist_sum;
    range_word_t       range_q[$];
    int                errors;

    function new();
      trig_len = TRIG_RESET;
      gap_len = GAP_RESET;
      phase = PH_IDLE;
      tick_cnt = '0;
      echo_cnt = '0;
      sample_idx = '0;
      dist_sum = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_TRIG) trig_len = value[TRIG_W-1:0];
      else gap_len = value[GAP_W-1:0];
    endfunction

    // Advance one tick and queue the range word it yields
    function void note_tick(tick_word_t w);
      range_word_t want;
      longint factor, sample_dist, total, avg;
      want = '0;
      case (phase)
        PH_TRIG: begin
          if (tick_cnt >= GAP_W'(trig_len)) begin
            phase = PH_RISE;
            tick_cnt = '0;
          end else begin
            tick_cnt = tick_cnt + 1'b1;
          end
        end
        PH_RISE: begin
          if (w.echo) begin
            phase = PH_ECHO;
            echo_cnt = ECHO_W'(1);
          end
        end
        PH_ECHO: begin
          if (w.echo) begin
            // saturate the echo count
            if (echo_cnt != '1) echo_cnt = echo_cnt + 1'b1;
          end else begin
            factor = SOUND_BASE + SOUND_SLOPE * longint'($signed(w.temperature));
            sample_dist = (longint'(echo_cnt) * factor) / RANGE_SCALE;
            total = longint'(dist_sum) + sample_dist;
            dist_sum = (total > SUM_CEIL) ? SUM_W'(SUM_CEIL) : total[SUM_W-1:0];
            sample_idx = sample_idx + 1'b1;
            phase = PH_GAP;
            tick_cnt = '0;
          end
        end
        PH_GAP: begin
          if (tick_cnt >= gap_len) begin
            if (int'(sample_idx) >= AVG_COUNT) begin
              avg = longint'(dist_sum) / AVG_COUNT;
              if (avg > DIST_CEIL) avg = DIST_CEIL;
              want.done_res = 1'b1;
              want.distance = avg[DIST_W-1:0];
              phase = PH_IDLE;
              tick_cnt = '0;
            end else begin
              phase = PH_TRIG;
              tick_cnt = GAP_W'(1);
            end
          end else begin
            tick_cnt = tick_cnt + 1'b1;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (w.start_req) begin
            phase = PH_TRIG;
            tick_cnt = GAP_W'(1);
            echo_cnt = '0;
            sample_idx = '0;
            dist_sum = '0;
          end
        end
      endcase
      want.trigger = (phase == PH_TRIG);
      want.busy_res = (phase != PH_IDLE);
      range_q.push_back(want);
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    // Compare one range word with the oldest one queued
    function void check_range(range_word_t got);
      range_word_t want;
      if (range_q.size() == 0) begin
        errors++;
        $display("%0t: range word %h with none expected", $time, got);
        return;
      end
      want = range_q.pop_front();
      if (got.trigger !== want.trigger) report("trigger", want.trigger, got.trigger);
      if (got.busy_res !== want.busy_res) report("busy_res", want.busy_res, got.busy_res);
      if (got.done_res !== want.done_res) report("done_res", want.done_res, got.done_res);
      if (got.distance !== want.distance) report("distance", want.distance, got.distance);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [23:0]      out_tdata;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bit quiet;
  bit hold_req;
  int cycles;
  range_scoreboard sb;

  ultrasonic_range_averager_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both handshakes on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[13:0]);
      if (out_tvalid && out_tready) sb.check_range(out_tdata[20:0]);
    end
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** ultrasonic_range_averager_top: FAILED **");
        $finish;
      end
    end
  end

  // Drive the receiver: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  function automatic logic [TEMP_W-1:0] rand_temp();
    int v;
    if ($urandom_range(9) == 0) return TEMP_W'($urandom);
    v = int'($urandom_range(2880)) - 880;
    return v[TEMP_W-1:0];
  endfunction

  // Offer one tick word and hold it until taken
  task automatic send_tick(input bit start_req, input bit echo, input logic [TEMP_W-1:0] temp);
    tick_word_t w;
    w.start_req = start_req;
    w.echo = echo;
    w.temperature = temp;
    if (!quiet && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (sb.range_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Feed ticks shaped by the tracked phase: mostly clean echoes, some noise
  task automatic feed(input int n);
    bit st, ec;
    repeat (n) begin
      case (sb.phase)
        PH_IDLE: begin
          st = ($urandom_range(9) < 7);
          ec = 1'($urandom_range(1));
        end
        PH_RISE: begin
          st = 1'($urandom_range(1));
          ec = ($urandom_range(2) == 0);
        end
        PH_ECHO: begin
          st = 1'($urandom_range(1));
          ec = ($urandom_range(4) != 0);
        end
        default: begin
          st = 1'($urandom_range(1));
          ec = 1'($urandom_range(1));
        end
      endcase
      send_tick(st, ec, rand_temp());
    end
  endtask

  // Run one measurement from the trigger on; starts are offered while busy
  task automatic measure(input int rise_wait, input int echo_len, input logic [TEMP_W-1:0] fall_temp);
    while (sb.phase == PH_TRIG) send_tick(1'b1, 1'b0, rand_temp());
    repeat (rise_wait) send_tick(1'b1, 1'b0, rand_temp());
    repeat (echo_len) send_tick(1'b0, 1'b1, rand_temp());
    send_tick(1'b1, 1'b0, fall_temp);
    while (sb.phase == PH_GAP) send_tick(1'b1, 1'b1, rand_temp());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TRIG;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle ticks at the temperature extremes
    send_tick(1'b0, 1'b1, 12'h800);
    send_tick(1'b0, 1'b1, 12'h7FF);
    send_tick(1'b0, 1'b0, 12'hC90);
    send_tick(1'b0, 1'b0, 12'h7D0);

    // Zero trigger length and zero gap, shortest echo, coldest reading
    write_reg(CFG_TRIG, 17'h1FF00);
    write_reg(CFG_GAP, '0);
    send_tick(1'b1, 1'b0, rand_temp());
    repeat (AVG_COUNT) measure(0, 1, 12'h800);
    send_tick(1'b1, 1'b0, rand_temp());

    // Random phases under several settings
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_TRIG, {9'($urandom), 8'((p == 0) ? 1 : $urandom_range(1, 6))});
      write_reg(CFG_GAP, CFG_W'($urandom_range(0, 10)));
      quiet = (p == 2);
      if (p == 1) begin
        feed(60);
        hold_req = 1'b1;
        feed(115);
      end else begin
        feed(175);
      end
    end
    quiet = 1'b0;

    // Finish the running sequence before the long settings
    while (sb.phase != PH_IDLE) feed(1);
    write_reg(CFG_TRIG, {9'($urandom), 8'hFF});
    write_reg(CFG_GAP, 17'h1FFFF);

    // Longest trigger, a long wait for echo, hottest word at the fall
    send_tick(1'b1, 1'b0, rand_temp());
    while (sb.phase == PH_TRIG) send_tick(1'b1, 1'b0, rand_temp());
    repeat (30) send_tick(1'b1, 1'b0, rand_temp());
    repeat (40) send_tick(1'b0, 1'b1, rand_temp());
    send_tick(1'b0, 1'b0, 12'h7FF);
    repeat (20) send_tick(1'b1, 1'($urandom_range(1)), rand_temp());

    // Cut the long gap short and let the sequence end
    write_reg(CFG_GAP, CFG_W'(3));
    write_reg(CFG_TRIG, CFG_W'(2));
    while (sb.phase != PH_IDLE) feed(1);
    feed(20);

    wait_drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.range_q.size() == 0) begin
      $display("** ultrasonic_range_averager_top: PASSED **");
    end else begin
      $display("** ultrasonic_range_averager_top: FAILED **");
    end
    $finish;
  end

endmodule
